/* hw/rtl/sul_pkg.sv */
// Package of shared codes and types for the sphere union level-set block.
`timescale 1ns / 1ps

package sul_pkg;

  typedef enum logic [1:0] {
    MODE_QUERY  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_SPARE  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_QUERY_DONE = 2'd0,
    ST_STORED     = 2'd1,
    ST_FULL       = 2'd2,
    ST_CLEARED    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DIFF,
    S_SQUARE,
    S_ROOT,
    S_CMP,
    S_FIN
  } state_e;

  localparam logic CFG_PLANE_HEIGHT = 1'b0;
  localparam logic CFG_DIMENSION    = 1'b1;

  localparam logic [1:0] DIM_THREE = 2'd3;

  // Root of a 66-bit square sum: two radicand bits per step.
  localparam int unsigned RootSteps = 33;

  localparam int unsigned EntryW = 127;

endpackage

/* hw/rtl/sphere_union_level_set.sv */
// Level-set value of a union of stored spheres and a flat plane.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  in      | input     | in_valid_i / in_stall_o| mode, x, y, z, radius, last_in
//  out     | output    | out_valid_o/out_stall_i| phi, status, last_out
//  cfg     | input     | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// Append and clear go straight to the final state. A query walks the N stored
// spheres: per sphere one memory read, one difference, the shared squarer over
// the three differences, 33 root steps and one compare.
// Reset empties the table count; the sphere memory itself is not cleared.
// A waiting result holds in the output register; the next item is still taken
// and holds in its final state until that register frees.
`timescale 1ns / 1ps

module sphere_union_level_set #(
  parameter int unsigned MAX_SPHERES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [31:0] x_i,
  input  logic [31:0] y_i,
  input  logic [31:0] z_i,
  input  logic [30:0] radius_i,
  input  logic        last_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] phi_o,
  output logic [1:0]  status_o,
  output logic        last_out_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i
);
  import sul_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_SPHERES + 1);
  localparam int unsigned IdxW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_SPHERES);

  logic [EntryW-1:0] mem_q [MAX_SPHERES];
  logic [EntryW-1:0] rd_q;

  state_e state_q, state_d;
  logic [CntW-1:0] count_q, idx_q;
  logic [5:0]  step_q;
  logic [31:0] plane_q;
  logic [1:0]  dim_q;

  logic signed [31:0] qx_q, qy_q, qz_q;
  logic [32:0] dx_q, dy_q, dz_q;
  logic [65:0] prod_q, sum_q, n_q;
  logic [35:0] rem_q;
  logic [32:0] root_q;
  logic signed [35:0] best_q;
  logic [1:0]  status_q;
  logic        last_q;

  logic        out_valid_q;
  logic [31:0] phi_q;
  logic [1:0]  out_status_q;
  logic        out_last_q;

  logic accept, out_free;
  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  // Datapath helpers
  logic [30:0] c_rad;
  logic [31:0] c_x, c_y, c_z;
  assign {c_x, c_y, c_z, c_rad} = rd_q;

  function automatic logic [32:0] abs_diff(logic [31:0] a, logic [31:0] b);
    logic signed [32:0] d;
    d = $signed({a[31], a}) - $signed({b[31], b});
    return d[32] ? 33'(-d) : 33'(d);
  endfunction

  logic [32:0] sq_op;
  always_comb begin
    unique case (step_q[1:0])
      2'd0:    sq_op = dx_q;
      2'd1:    sq_op = dy_q;
      default: sq_op = dz_q;
    endcase
  end

  logic [35:0] rem_sh, trial;
  logic        take;
  assign rem_sh = {rem_q[33:0], n_q[65:64]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign take   = (rem_sh >= trial);

  logic signed [35:0] term;
  assign term = $signed({5'b0, c_rad}) - $signed({3'b0, root_q});

  logic signed [31:0] z_eff;
  assign z_eff = (dim_q == DIM_THREE) ? $signed(z_i) : 32'sd0;

  logic signed [31:0] best_sat;
  always_comb begin
    priority if (best_q > 36'sh0_7FFF_FFFF) begin
      best_sat = 32'sh7FFF_FFFF;
    end else if (best_q < -36'sh0_8000_0000) begin
      best_sat = 32'sh8000_0000;
    end else begin
      best_sat = best_q[31:0];
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if ((mode_i == MODE_APPEND) || (mode_i == MODE_CLEAR) || (count_q == '0)) begin
            state_d = S_FIN;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_READ:   state_d = S_DIFF;
      S_DIFF:   state_d = S_SQUARE;
      S_SQUARE: if (step_q == 6'd3) state_d = S_ROOT;
      S_ROOT:   if (step_q == 6'(RootSteps - 1)) state_d = S_CMP;
      S_CMP:    state_d = (idx_q + 1'b1 < count_q) ? S_READ : S_FIN;
      S_FIN:    if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      plane_q     <= '0;
      dim_q       <= DIM_THREE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_PLANE_HEIGHT: plane_q <= cfg_data_i;
          CFG_DIMENSION:    dim_q   <= cfg_data_i[1:0];
          default: ;
        endcase
      end
      if (accept && mode_i == MODE_APPEND && count_q < MaxCnt) count_q <= count_q + 1'b1;
      if (accept && mode_i == MODE_CLEAR) count_q <= '0;
      if (state_q == S_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Sphere memory
  always_ff @(posedge clk_i) begin
    if (accept && mode_i == MODE_APPEND && count_q < MaxCnt) begin
      mem_q[count_q[IdxW-1:0]] <= {x_i, y_i, z_i, radius_i};
    end
    if (state_q == S_READ) rd_q <= mem_q[idx_q[IdxW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          qx_q   <= x_i;
          qy_q   <= y_i;
          qz_q   <= z_eff;
          idx_q  <= '0;
          last_q <= last_in_i;
          best_q <= $signed({{4{plane_q[31]}}, plane_q}) - 36'(z_eff);
          unique case (mode_i)
            MODE_APPEND: status_q <= (count_q < MaxCnt) ? ST_STORED : ST_FULL;
            MODE_CLEAR:  status_q <= ST_CLEARED;
            default:     status_q <= ST_QUERY_DONE;
          endcase
        end
      end
      S_DIFF: begin
        dx_q   <= abs_diff(qx_q, c_x);
        dy_q   <= abs_diff(qy_q, c_y);
        dz_q   <= abs_diff(qz_q, c_z);
        sum_q  <= '0;
        step_q <= '0;
      end
      S_SQUARE: begin
        // Square one difference a cycle; add the previous product.
        if (step_q != 6'd3) prod_q <= sq_op * sq_op;
        if (step_q != 6'd0) sum_q <= sum_q + prod_q;
        if (step_q == 6'd3) begin
          n_q    <= sum_q + prod_q;
          rem_q  <= '0;
          root_q <= '0;
          step_q <= '0;
        end else begin
          step_q <= step_q + 1'b1;
        end
      end
      S_ROOT: begin
        rem_q  <= take ? rem_sh - trial : rem_sh;
        root_q <= {root_q[31:0], take};
        n_q    <= {n_q[63:0], 2'b00};
        step_q <= step_q + 1'b1;
      end
      S_CMP: begin
        if (term > best_q) best_q <= term;
        idx_q <= idx_q + 1'b1;
      end
      S_FIN: begin
        if (out_free) begin
          phi_q        <= (status_q == ST_QUERY_DONE) ? best_sat : 32'd0;
          out_status_q <= status_q;
          out_last_q   <= last_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign phi_o       = phi_q;
  assign status_o    = out_status_q;
  assign last_out_o  = out_last_q;

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxCnt) else $error("sphere count beyond table depth");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != S_IDLE) else $error("accepted item left no work");
  a_walk_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> (idx_q < count_q)) else $error("read beyond stored spheres");
endmodule

/* dv/testbench.sv */
// Self-checking testbench for the sphere union level-set block.
`timescale 1ns / 1ps

module testbench;
  import sul_pkg::*;

  localparam int unsigned NumSpheres = 256;

  typedef struct {
    logic [1:0]  mode;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [30:0] radius;
    logic        last;
  } item_t;

  typedef struct {
    logic [31:0] phi;
    logic [1:0]  status;
    logic        last;
  } level_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  mode_i = '0;
  logic [31:0] x_i = '0;
  logic [31:0] y_i = '0;
  logic [31:0] z_i = '0;
  logic [30:0] radius_i = '0;
  logic        last_in_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] phi_o;
  logic [1:0]  status_o;
  logic        last_out_o;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [31:0] cfg_data_i = '0;

  sphere_union_level_set u_top (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predictor state.
  logic signed [63:0] ball_x [NumSpheres];
  logic signed [63:0] ball_y [NumSpheres];
  logic signed [63:0] ball_z [NumSpheres];
  logic signed [63:0] ball_r [NumSpheres];
  int unsigned        ball_count;
  logic signed [63:0] bed_height;
  logic [1:0]         dim_sel;

  level_t      level_q[$];
  int unsigned errors;
  longint      cycles;
  bit          hold_long;
  int unsigned hold_cycles;
  bit          quiet_out;

  function automatic logic [65:0] floor_root(logic [65:0] sum);
    logic [33:0]  root;
    logic [33:0]  trial;
    logic [67:0]  sq;
    root = '0;
    for (int k = 33; k >= 0; k--) begin
      trial = root | (34'd1 << k);
      sq = trial * trial;
      if (sq <= {2'b00, sum}) root = trial;
    end
    return {32'd0, root};
  endfunction

  function automatic level_t predict_level(item_t it);
    level_t             res;
    logic signed [63:0] px, py, pz, best, term, dx, dy, dz;
    logic [65:0]        sum;
    res.phi = '0;
    res.last = it.last;
    px = $signed(it.x);
    py = $signed(it.y);
    pz = $signed(it.z);
    case (mode_e'(it.mode))
      MODE_APPEND: begin
        if (ball_count < NumSpheres) begin
          ball_x[ball_count] = px;
          ball_y[ball_count] = py;
          ball_z[ball_count] = pz;
          ball_r[ball_count] = {33'd0, it.radius};
          ball_count++;
          res.status = ST_STORED;
        end else begin
          res.status = ST_FULL;
        end
      end
      MODE_CLEAR: begin
        ball_count = 0;
        res.status = ST_CLEARED;
      end
      default: begin
        if (dim_sel != DIM_THREE) pz = 0;
        best = bed_height - pz;
        for (int i = 0; i < ball_count; i++) begin
          dx = px - ball_x[i];
          dy = py - ball_y[i];
          dz = pz - ball_z[i];
          if (dx < 0) dx = -dx;
          if (dy < 0) dy = -dy;
          if (dz < 0) dz = -dz;
          sum = 66'($unsigned(dx * dx)) + 66'($unsigned(dy * dy)) +
                66'($unsigned(dz * dz));
          term = ball_r[i] - $signed(64'(floor_root(sum)));
          if (term > best) best = term;
        end
        if (best > 64'sd2147483647) best = 64'sd2147483647;
        if (best < -64'sd2147483648) best = -64'sd2147483648;
        res.phi = best[31:0];
        res.status = ST_QUERY_DONE;
      end
    endcase
    return res;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_item(item_t it);
    int unsigned g;
    g = quiet_out ? 0 : gap_len();
    if (g != 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= it.mode;
    x_i <= it.x;
    y_i <= it.y;
    z_i <= it.z;
    radius_i <= it.radius;
    last_in_i <= it.last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    level_q.insert(level_q.size(), predict_level(it));
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (level_q.size() != 0) @(posedge clk_i);
    // every item gives a result, nothing silent; short margin
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_PLANE_HEIGHT) bed_height = $signed(data);
    else dim_sel = data[1:0];
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom;
      default: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
    endcase
  endfunction

  function automatic item_t make_item(logic [1:0] mode);
    item_t it;
    it.mode = mode;
    it.x = rand_coord();
    it.y = rand_coord();
    it.z = rand_coord();
    it.radius = ($urandom_range(0, 9) == 0) ? 31'($urandom) : 31'($urandom_range(0, 8 << 16));
    it.last = 1'($urandom);
    return it;
  endfunction

  task automatic test_directed();
    item_t it;
    it = '{MODE_QUERY, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 31'd0, 1'b1};
    send_item(it);
    it = '{MODE_APPEND, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 31'h7fff_ffff, 1'b0};
    send_item(it);
    it = '{MODE_APPEND, 32'd0, 32'd0, 32'd0, 31'h0001_0000, 1'b1};
    send_item(it);
    it = '{MODE_QUERY, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff, 1'b0};
    send_item(it);
    it = '{MODE_SPARE, 32'd0, 32'd0, 32'h0000_8000, 31'd5, 1'b1};
    send_item(it);
    it = '{MODE_QUERY, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 31'd0, 1'b0};
    send_item(it);
    it = '{MODE_CLEAR, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 31'h7fff_ffff, 1'b1};
    send_item(it);
    it = '{MODE_QUERY, 32'd3, 32'd4, 32'h7fff_ffff, 31'd0, 1'b0};
    send_item(it);
    wait_drain();
    write_reg(CFG_PLANE_HEIGHT, 32'h7fff_ffff);
    write_reg(CFG_DIMENSION, 32'd2);
    it = '{MODE_APPEND, 32'd0, 32'd0, 32'h0003_0000, 31'h0005_0000, 1'b0};
    send_item(it);
    it = '{MODE_QUERY, 32'd0, 32'h0004_0000, 32'h8000_0000, 31'd0, 1'b1};
    send_item(it);
    wait_drain();
    write_reg(CFG_PLANE_HEIGHT, 32'h8000_0000);
    write_reg(CFG_DIMENSION, 32'd3);
    it = '{MODE_QUERY, 32'd0, 32'd0, 32'h7fff_ffff, 31'd0, 1'b0};
    send_item(it);
    wait_drain();
  endtask

  // Hold the output while filling to capacity and past it, then query the full table and clear it.
  task automatic test_full_table();
    hold_cycles = 3000;
    hold_long = 1'b1;
    it_loop: for (int i = 0; i < NumSpheres + 3; i++) send_item(make_item(MODE_APPEND));
    for (int i = 0; i < 4; i++) send_item(make_item(MODE_QUERY));
    send_item(make_item(MODE_CLEAR));
    wait_drain();
  endtask

  // Build small tables and probe them; most items are queries.
  task automatic test_random(int unsigned n, logic [31:0] height, logic [1:0] dim);
    int unsigned r;
    write_reg(CFG_PLANE_HEIGHT, height);
    write_reg(CFG_DIMENSION, 32'(dim));
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 4) send_item(make_item(MODE_CLEAR));
      else if (r < 30 && ball_count < 12) send_item(make_item(MODE_APPEND));
      else if (r < 33) send_item(make_item(MODE_SPARE));
      else send_item(make_item(MODE_QUERY));
    end
    wait_drain();
  endtask

  // Output side: random stalls (none while quiet_out is set), plus one long hold on request.
  always @(posedge clk_i) begin
    if (hold_long) begin
      out_stall_i <= 1'b1;
      if (hold_cycles == 0) hold_long <= 1'b0;
      else hold_cycles <= hold_cycles - 1;
    end else if (quiet_out) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < 25);
    end
  end

  // Compare each result with the oldest prediction.
  always @(posedge clk_i) begin
    level_t exp;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (level_q.size() == 0) begin
        $display("%0t: unexpected result phi=%h status=%0d", $time, phi_o, status_o);
        errors++;
      end else begin
        exp = level_q.pop_front();
        if (phi_o !== exp.phi) begin
          $display("%0t: phi expected %h actual %h", $time, exp.phi, phi_o);
          errors++;
        end
        if (status_o !== exp.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp.status, status_o);
          errors++;
        end
        if (last_out_o !== exp.last) begin
          $display("%0t: last expected %0d actual %0d", $time, exp.last, last_out_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 1500000) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    errors = 0;
    cycles = 0;
    hold_long = 1'b0;
    hold_cycles = 0;
    quiet_out = 1'b0;
    ball_count = 0;
    bed_height = 0;
    dim_sel = DIM_THREE;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_table();
    test_random(150, $urandom, 2'd3);
    test_random(120, 32'h0000_0000, 2'd2);
    quiet_out = 1'b1;
    test_random(80, 32'h8000_0000, 2'd0);
    quiet_out = 1'b0;
    test_random(80, 32'h7fff_ffff, 2'd1);
    test_random(100, 32'h0002_0000, 2'd3);
    if (errors == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/sul_pkg.sv
hw/rtl/sphere_union_level_set.sv
dv/testbench.sv
